// ===== hdl/rwre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwre_pkg: shared types and constants
// Beat layouts, opcodes and the low/high pair used by the ring and the
// compare unit.
// ----------------------------------------------------------------------------
package rwre_pkg;

  localparam int unsigned WINDOW_HOURS_DEF = 24;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_PUBLISH = 2'd1,
    OP_ROLL    = 2'd2,
    OP_NONE    = 2'd3
  } rwre_op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] heart_rate;
  } rwre_in_t;

  typedef struct packed {
    logic [7:0] current_rate;
    logic [7:0] hour_low;
    logic [7:0] hour_high;
    logic       hour_valid;
    logic [7:0] day_low;
    logic [7:0] day_high;
    logic       day_valid;
  } rwre_out_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
  } rwre_pair_t;

  // Control of the shared compare unit.
  typedef struct packed {
    logic clear;
    logic feed;
  } rwre_cmp_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/rwre_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwre_ring: ring of completed-hour pairs
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rwre_ring #(
  parameter int unsigned DEPTH = rwre_pkg::WINDOW_HOURS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire rwre_pkg::rwre_pair_t wr_data,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output rwre_pkg::rwre_pair_t     rd_data
);
  import rwre_pkg::*;

  rwre_pair_t mem [DEPTH];
  rwre_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/rwre_minmax.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwre_minmax: shared low/high compare unit
// Folds one pair per cycle while feed is set into a running low/high with a have flag.
// ----------------------------------------------------------------------------
module rwre_minmax (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rwre_pkg::rwre_cmp_ctl_t ctl,
  input  wire rwre_pkg::rwre_pair_t  data,
  output rwre_pkg::rwre_pair_t       acc,
  output logic                       have
);
  import rwre_pkg::*;

  rwre_pair_t acc_r, acc_nxt;
  logic       have_r, have_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    have_nxt = have_r;
    if (ctl.clear) begin
      acc_nxt  = '0;
      have_nxt = 1'b0;
    end else if (ctl.feed) begin
      if (!have_r || (data.lo < acc_r.lo)) acc_nxt.lo = data.lo;
      if (!have_r || (data.hi > acc_r.hi)) acc_nxt.hi = data.hi;
      have_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      have_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      have_r <= have_nxt;
    end
  end

  assign acc  = acc_r;
  assign have = have_r;

endmodule
`default_nettype wire

// ===== hdl/rolling_window_rate_extremes.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_window_rate_extremes: hourly and sliding-window heart-rate extremes
// Tracks the current hour's low/high and a ring of completed hours, and
// reports the window low/high after every sample or hour rollover.
// ----------------------------------------------------------------------------
// One beat in gives one beat out (opcode 3 gives none). A sample (opcode 0,
// or 1 to also publish the hour pair) folds into the current hour; a rollover
// (opcode 2) pushes a non-empty hour into a ring of WINDOW_HOURS pairs,
// overwriting the oldest once full, and publishes it. Each item then rescans
// the ring through a single shared compare unit, one stored pair per cycle
// from a one-read-port memory, and finally folds in the current hour after a
// sample. The scan covers the stored hours, at most WINDOW_HOURS. in_ready
// stays low from acceptance through the scan, the hour fold and the hand-off
// to the output register, so no new beat is taken while one is in flight.
// The finished result sits in an output register, so the next beat may be
// accepted while it waits; a result still held there when the next one is
// done holds the block until it drains. Ring entries need no clearing: only
// the filled part is ever read.
// ----------------------------------------------------------------------------
module rolling_window_rate_extremes #(
  parameter int unsigned WINDOW_HOURS = rwre_pkg::WINDOW_HOURS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rwre_pkg::rwre_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rwre_pkg::rwre_out_t     out_data
);
  import rwre_pkg::*;

  localparam int unsigned AW = (WINDOW_HOURS > 1) ? $clog2(WINDOW_HOURS) : 1;
  localparam int unsigned CW = $clog2(WINDOW_HOURS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOUR,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;

  // Current hour
  logic [7:0]    hour_min_r, hour_min_nxt;
  logic [7:0]    hour_max_r, hour_max_nxt;
  logic          hour_has_r, hour_has_nxt;

  // Ring bookkeeping
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] next_r, next_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_v_r, rd_v_nxt;

  // Pending result fields of the item in flight
  logic [7:0]    cur_r, cur_nxt;
  logic [7:0]    hlo_r, hlo_nxt;
  logic [7:0]    hhi_r, hhi_nxt;
  logic          hval_r, hval_nxt;
  logic          with_hour_r, with_hour_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  rwre_out_t     out_data_r, out_data_nxt;

  // Ring and compare unit hookup
  logic          wr_en, rd_en;
  rwre_pair_t    wr_data, rd_data;
  rwre_pair_t    cmp_data, acc;
  logic          acc_have;
  rwre_cmp_ctl_t cmp_ctl;
  logic [7:0]    hr;

  assign hr      = in_data.heart_rate;
  assign wr_data = '{lo: hour_min_r, hi: hour_max_r};

  always_comb begin
    state_nxt     = state_r;
    hour_min_nxt  = hour_min_r;
    hour_max_nxt  = hour_max_r;
    hour_has_nxt  = hour_has_r;
    fill_nxt      = fill_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    hlo_nxt       = hlo_r;
    hhi_nxt       = hhi_r;
    hval_nxt      = hval_r;
    with_hour_nxt = with_hour_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    cmp_ctl       = '0;
    cmp_data      = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (rwre_op_t'(in_data.opcode))
            OP_SAMPLE, OP_PUBLISH: begin
              // Seed on the first sample of the hour, else widen.
              if (!hour_has_r) begin
                hour_min_nxt = hr;
                hour_max_nxt = hr;
              end else begin
                if (hr < hour_min_r) hour_min_nxt = hr;
                if (hr > hour_max_r) hour_max_nxt = hr;
              end
              hour_has_nxt  = 1'b1;
              cur_nxt       = hr;
              hval_nxt      = (rwre_op_t'(in_data.opcode) == OP_PUBLISH);
              hlo_nxt       = (rwre_op_t'(in_data.opcode) == OP_PUBLISH) ? hour_min_nxt : 8'd0;
              hhi_nxt       = (rwre_op_t'(in_data.opcode) == OP_PUBLISH) ? hour_max_nxt : 8'd0;
              with_hour_nxt = 1'b1;
              idx_nxt       = '0;
              cmp_ctl.clear = 1'b1;
              state_nxt     = S_SCAN;
            end
            OP_ROLL: begin
              cur_nxt  = 8'd0;
              hval_nxt = hour_has_r;
              hlo_nxt  = hour_has_r ? hour_min_r : 8'd0;
              hhi_nxt  = hour_has_r ? hour_max_r : 8'd0;
              if (hour_has_r) begin
                // Push the hour, advance the write slot, drop the hour.
                wr_en    = 1'b1;
                next_nxt = (next_r == AW'(WINDOW_HOURS - 1)) ? '0 : next_r + AW'(1);
                if (fill_r < CW'(WINDOW_HOURS)) fill_nxt = fill_r + CW'(1);
                hour_min_nxt = 8'd0;
                hour_max_nxt = 8'd0;
                hour_has_nxt = 1'b0;
              end
              with_hour_nxt = 1'b0;
              idx_nxt       = '0;
              cmp_ctl.clear = 1'b1;
              state_nxt     = S_SCAN;
            end
            default: begin
              // Unused opcode: no change, no result.
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue one read per cycle, fold the pair that returns.
        cmp_ctl.feed = rd_v_r;
        if (idx_r < fill_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else if (!rd_v_r) begin
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        cmp_data     = '{lo: hour_min_r, hi: hour_max_r};
        cmp_ctl.feed = with_hour_r && hour_has_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.current_rate = cur_r;
          out_data_nxt.hour_low     = hlo_r;
          out_data_nxt.hour_high    = hhi_r;
          out_data_nxt.hour_valid   = hval_r;
          out_data_nxt.day_low      = acc_have ? acc.lo : 8'd0;
          out_data_nxt.day_high     = acc_have ? acc.hi : 8'd0;
          out_data_nxt.day_valid    = acc_have;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    rd_v_nxt = rd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hour_min_r  <= 8'd0;
      hour_max_r  <= 8'd0;
      hour_has_r  <= 1'b0;
      fill_r      <= '0;
      next_r      <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hour_min_r  <= hour_min_nxt;
      hour_max_r  <= hour_max_nxt;
      hour_has_r  <= hour_has_nxt;
      fill_r      <= fill_nxt;
      next_r      <= next_nxt;
      idx_r       <= idx_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    hlo_r       <= hlo_nxt;
    hhi_r       <= hhi_nxt;
    hval_r      <= hval_nxt;
    with_hour_r <= with_hour_nxt;
    out_data_r  <= out_data_nxt;
  end

  rwre_ring #(
    .DEPTH (WINDOW_HOURS),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (next_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  rwre_minmax u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cmp_ctl),
    .data  (cmp_data),
    .acc   (acc),
    .have  (acc_have)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Ring never counts more hours than it holds.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(WINDOW_HOURS))
    else $error("ring fill exceeds window");

  // Window extremes are ordered whenever reported valid.
  a_day_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.day_valid) |-> (out_data_r.day_low <= out_data_r.day_high))
    else $error("day low above day high");

  // Published hour pair is ordered.
  a_hour_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hour_valid) |-> (out_data_r.hour_low <= out_data_r.hour_high))
    else $error("hour low above hour high");

  // Pushing a non-empty hour leaves the ring non-empty.
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.opcode == OP_ROLL) && hour_has_r) |=> (fill_r != '0))
    else $error("push did not fill ring");

  // Reads are issued only during the scan.
  a_read_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == S_SCAN))
    else $error("ring read outside scan");

endmodule
`default_nettype wire
